/* hw/rtl/lrps_pkg.sv */
// ----------------------------------------------------------------------------
// lrps_pkg: shared types and codes for the latching relay pulse sequencer
// Word layouts, register map, mode and status codes, sequencer phases.
// ----------------------------------------------------------------------------
package lrps_pkg;

  localparam int unsigned TickW    = 16;
  localparam int unsigned ChanW    = 2;
  localparam int unsigned ActW     = 2;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CoilW    = 12;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  localparam logic [TickW-1:0] PulseTicksRst    = 16'd50;
  localparam logic [TickW-1:0] FeedbackTicksRst = 16'd100;
  localparam logic [TickW-1:0] TickMax          = 16'hFFFF;

  typedef enum logic [ModeW-1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_TAKE  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BUSY   = 2'd1,
    STATUS_REJECT = 2'd2
  } status_e;

  localparam logic [ActW-1:0]  ActOpen  = 2'd1;
  localparam logic [ActW-1:0]  ActClose = 2'd2;
  localparam logic [ChanW-1:0] ChanNone = 2'd0;

  // Coil nibble per channel: relay1 on, relay2 on, relay1 off, relay2 off
  localparam logic [3:0] NibOpen  = 4'h3;
  localparam logic [3:0] NibClose = 4'hC;

  typedef enum logic [0:0] {
    REG_PULSE_TICKS    = 1'b0,
    REG_FEEDBACK_TICKS = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PULSE = 3'b010,
    PH_WAIT  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [ChanW-1:0] channel;
    logic [ActW-1:0]  action;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] start_status;
    logic [CoilW-1:0]   coil_drive;
    logic               busy_res;
    logic               done_valid;
    logic [ChanW-1:0]   done_channel;
    logic [ActW-1:0]    done_action;
  } out_item_t;

  typedef struct packed {
    logic [TickW-1:0] pulse_ticks;
    logic [TickW-1:0] feedback_wait_ticks;
  } cfg_t;

endpackage

/* hw/rtl/latching_relay_pulse_sequencer_core.sv */
// ----------------------------------------------------------------------------
// latching_relay_pulse_sequencer_core: three-channel latching relay sequencer
// Pulses the open or close coils of a relay pair, waits for feedback, then
// latches a done event that a take request collects.
// ----------------------------------------------------------------------------
// One input word is taken per clock while the result buffer has room; its
// result word is written into that buffer. The whole update of the sequencer
// state (saturating tick count, one compare against the phase threshold,
// phase advance) is combinational. Results go through a two-entry buffer, so
// input is stalled only when the sink has held off two results. Timing
// registers are APB-written at 0x0 (pulse ticks), 0x4 (feedback wait ticks).
module latching_relay_pulse_sequencer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lrps_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lrps_pkg::out_item_t         out_item_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrps_pkg::PaddrW-1:0] paddr,
  input  logic [lrps_pkg::PdataW-1:0] pwdata,
  output logic [lrps_pkg::PdataW-1:0] prdata,
  output logic                        pready
);
  import lrps_pkg::*;

  cfg_t             cfg;
  logic             accept;
  logic             buf_full;
  out_item_t        res;

  phase_e           phase_q, phase_d;
  logic [TickW-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [ChanW-1:0] chan_q, chan_d;
  logic [ActW-1:0]  act_q, act_d;
  logic             pend_q, pend_d;
  logic [ChanW-1:0] done_chan_q, done_chan_d;
  logic [ActW-1:0]  done_act_q, done_act_d;
  mode_e            mode;
  logic [3:0]       nib;

  lrps_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o  = buf_full;
  assign accept      = in_valid_i & ~buf_full;
  assign mode        = mode_e'(in_item_i.mode);
  assign elapsed_inc = (elapsed_q == TickMax) ? elapsed_q : elapsed_q + 16'd1;

  always_comb begin
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    chan_d      = chan_q;
    act_d       = act_q;
    pend_d      = pend_q;
    done_chan_d = done_chan_q;
    done_act_d  = done_act_q;
    res         = '0;

    unique case (mode)
      MODE_TICK: begin
        unique case (phase_q)
          PH_PULSE: begin
            if (elapsed_inc >= cfg.pulse_ticks) begin
              elapsed_d = '0;
              phase_d   = PH_WAIT;
            end else begin
              elapsed_d = elapsed_inc;
            end
          end
          PH_WAIT: begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= cfg.feedback_wait_ticks) begin
              done_chan_d = chan_q;
              done_act_d  = act_q;
              pend_d      = 1'b1;
              chan_d      = ChanNone;
              act_d       = '0;
              phase_d     = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      MODE_START: begin
        priority if (phase_q != PH_IDLE) begin
          res.start_status = STATUS_BUSY;
        end else if (in_item_i.channel == ChanNone ||
                     (in_item_i.action != ActOpen && in_item_i.action != ActClose)) begin
          res.start_status = STATUS_REJECT;
        end else begin
          chan_d    = in_item_i.channel;
          act_d     = in_item_i.action;
          elapsed_d = '0;
          phase_d   = PH_PULSE;
          pend_d    = 1'b0;
        end
      end
      MODE_TAKE: begin
        if (pend_q) begin
          res.done_valid   = 1'b1;
          res.done_channel = done_chan_q;
          res.done_action  = done_act_q;
          pend_d           = 1'b0;
        end
      end
      default: ;
    endcase

    // Coils follow the state left by this word
    nib = (act_d == ActOpen) ? NibOpen : NibClose;
    if (phase_d == PH_PULSE) begin
      unique case (chan_d)
        2'd1:    res.coil_drive = {8'h00, nib};
        2'd2:    res.coil_drive = {4'h0, nib, 4'h0};
        2'd3:    res.coil_drive = {nib, 8'h00};
        default: res.coil_drive = '0;
      endcase
    end
    res.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      elapsed_q   <= '0;
      chan_q      <= ChanNone;
      act_q       <= '0;
      pend_q      <= 1'b0;
      done_chan_q <= '0;
      done_act_q  <= '0;
    end else if (accept) begin
      phase_q     <= phase_d;
      elapsed_q   <= elapsed_d;
      chan_q      <= chan_d;
      act_q       <= act_d;
      pend_q      <= pend_d;
      done_chan_q <= done_chan_d;
      done_act_q  <= done_act_d;
    end
  end

  lrps_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_item_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // A channel is held exactly while a sequence runs
  a_chan_tracks_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) == (chan_q == ChanNone))
    else $error("active channel out of step with phase");

  // A collected done event is gone afterwards
  a_take_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode == MODE_TAKE) |=> !pend_q)
    else $error("done event still pending after take");

  // Coils are driven only in a busy sequence
  a_coil_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.coil_drive == '0 || out_item_o.busy_res))
    else $error("coil driven while idle");

  // Input stalls only when results are waiting
  a_stall_has_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result buffer");

endmodule

/* hw/rtl/lrps_apb_regs.sv */
// ----------------------------------------------------------------------------
// lrps_apb_regs: configuration registers
// Two 16-bit timing registers behind an APB-style port, always ready.
// ----------------------------------------------------------------------------
module lrps_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrps_pkg::PaddrW-1:0] paddr,
  input  logic [lrps_pkg::PdataW-1:0] pwdata,
  output logic [lrps_pkg::PdataW-1:0] prdata,
  output logic                        pready,
  output lrps_pkg::cfg_t              cfg_o
);
  import lrps_pkg::*;

  logic     wr_en;
  reg_idx_e idx;
  cfg_t     cfg_q;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_ticks         <= PulseTicksRst;
      cfg_q.feedback_wait_ticks <= FeedbackTicksRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_PULSE_TICKS:    cfg_q.pulse_ticks         <= pwdata[TickW-1:0];
        REG_FEEDBACK_TICKS: cfg_q.feedback_wait_ticks <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PULSE_TICKS:    prdata[TickW-1:0] = cfg_q.pulse_ticks;
      REG_FEEDBACK_TICKS: prdata[TickW-1:0] = cfg_q.feedback_wait_ticks;
      default: ;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/lrps_out_buf.sv */
// ----------------------------------------------------------------------------
// lrps_out_buf: result buffer
// Two-entry result queue; takes a word each cycle while the sink drains.
// ----------------------------------------------------------------------------
module lrps_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lrps_pkg::out_item_t  push_item_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lrps_pkg::out_item_t  out_item_o
);
  import lrps_pkg::*;

  out_item_t   slot_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        pop;

  assign pop         = out_valid_o & ~out_stall_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign out_item_o  = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    priority if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_item_i;
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: latching relay pulse sequencer core
// Runs a short directed pass over every command and corner, a back-pressure
// pass and phased random traffic. Each accepted word goes through an
// in-bench model of the sequencer. The expected result words are queued and
// compared field by field with the words the block returns.
// ----------------------------------------------------------------------------
module testbench;
  import lrps_pkg::*;

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned RandomWords   = 1850;
  localparam int unsigned TrafficPhases = 8;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [PdataW-1:0]   pwdata;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  // sequencer model state
  phase_e              relay_phase;
  logic [TickW-1:0]    tick_count;
  logic [ChanW-1:0]    run_chan;
  logic [ActW-1:0]     run_act;
  logic                done_held;
  logic [ChanW-1:0]    held_chan;
  logic [ActW-1:0]     held_act;
  logic [TickW-1:0]    pulse_limit;
  logic [TickW-1:0]    settle_limit;

  out_item_t           expected_words[$];
  int unsigned         mismatches;
  int unsigned         cycle_count;
  bit                  calm;
  int unsigned         rx_hold_req;
  int unsigned         rx_hold_left;

  latching_relay_pulse_sequencer_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  // Advance the sequencer model by one word and return its result word.
  function automatic out_item_t advance_sequencer(input in_item_t w);
    out_item_t        r;
    logic [CoilW-1:0] nib;
    r = '0;
    case (w.mode)
      MODE_TICK: begin
        if (relay_phase != PH_IDLE) begin
          if (tick_count != TickMax) tick_count++;
          if (relay_phase == PH_PULSE) begin
            if (tick_count >= pulse_limit) begin
              tick_count  = '0;
              relay_phase = PH_WAIT;
            end
          end else if (tick_count >= settle_limit) begin
            held_chan   = run_chan;
            held_act    = run_act;
            done_held   = 1'b1;
            run_chan    = ChanNone;
            run_act     = '0;
            relay_phase = PH_IDLE;
          end
        end
      end
      MODE_START: begin
        if (relay_phase != PH_IDLE) begin
          r.start_status = STATUS_BUSY;
        end else if (w.channel == ChanNone ||
                     (w.action != ActOpen && w.action != ActClose)) begin
          r.start_status = STATUS_REJECT;
        end else begin
          run_chan    = w.channel;
          run_act     = w.action;
          tick_count  = '0;
          relay_phase = PH_PULSE;
          done_held   = 1'b0;
        end
      end
      MODE_TAKE: begin
        if (done_held) begin
          r.done_valid   = 1'b1;
          r.done_channel = held_chan;
          r.done_action  = held_act;
          done_held      = 1'b0;
        end
      end
      default: ;
    endcase
    if (relay_phase == PH_PULSE && run_chan != ChanNone) begin
      nib = (run_act == ActOpen) ? {8'h00, NibOpen} : {8'h00, NibClose};
      r.coil_drive = nib << (4 * (run_chan - 1));
    end
    r.busy_res = (relay_phase != PH_IDLE);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected word", 0, out_item);
      end else begin
        want = expected_words.pop_front();
        if (out_item.start_status !== want.start_status)
          note_mismatch("start_status", want.start_status, out_item.start_status);
        if (out_item.coil_drive !== want.coil_drive)
          note_mismatch("coil_drive", want.coil_drive, out_item.coil_drive);
        if (out_item.busy_res !== want.busy_res)
          note_mismatch("busy_res", want.busy_res, out_item.busy_res);
        if (out_item.done_valid !== want.done_valid)
          note_mismatch("done_valid", want.done_valid, out_item.done_valid);
        if (out_item.done_channel !== want.done_channel)
          note_mismatch("done_channel", want.done_channel, out_item.done_channel);
        if (out_item.done_action !== want.done_action)
          note_mismatch("done_action", want.done_action, out_item.done_action);
      end
    end
  end

  // result sink: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 17);
    end
  end

  function automatic in_item_t make_word(input mode_e m, input logic [ChanW-1:0] c,
                                         input logic [ActW-1:0] a);
    in_item_t w;
    w.mode    = m;
    w.channel = c;
    w.action  = a;
    return w;
  endfunction

  // Mostly ticks and well-formed starts; fields that a mode ignores stay random.
  function automatic in_item_t rand_word();
    int unsigned pick = $urandom_range(99);
    in_item_t    w;
    w.channel = ChanW'($urandom_range(3));
    w.action  = ActW'($urandom_range(3));
    if (pick < 55) begin
      w.mode = MODE_TICK;
    end else if (pick < 75) begin
      w.mode = MODE_START;
      if ($urandom_range(9) < 8) begin
        w.channel = ChanW'($urandom_range(1, 3));
        w.action  = $urandom_range(1) ? ActOpen : ActClose;
      end
    end else if (pick < 92) begin
      w.mode = MODE_TAKE;
    end else begin
      w.mode = MODE_NONE;
    end
    return w;
  endfunction

  task automatic send_word(input in_item_t w);
    if (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_words.push_back(advance_sequencer(w));
  endtask

  // Hold the input until every expected word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_access(input reg_idx_e idx, input logic wr,
                            input logic [TickW-1:0] val);
    logic [TickW-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= PdataW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    want = (idx == REG_PULSE_TICKS) ? pulse_limit : settle_limit;
    if (wr) begin
      if (idx == REG_PULSE_TICKS) pulse_limit = val;
      else settle_limit = val;
    end else if (prdata[TickW-1:0] !== want) begin
      note_mismatch("register read", want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(input logic [TickW-1:0] p, input logic [TickW-1:0] w);
    reg_access(REG_PULSE_TICKS, 1'b1, p);
    reg_access(REG_PULSE_TICKS, 1'b0, '0);
    reg_access(REG_FEEDBACK_TICKS, 1'b1, w);
    reg_access(REG_FEEDBACK_TICKS, 1'b0, '0);
  endtask

  task automatic test_register_reset();
    reg_access(REG_PULSE_TICKS, 1'b0, '0);
    reg_access(REG_FEEDBACK_TICKS, 1'b0, '0);
  endtask

  task automatic test_directed_sequence();
    set_timing(16'd0, 16'd0);
    send_word(make_word(MODE_TAKE, 2'd0, 2'd0));    // nothing pending
    send_word(make_word(MODE_TICK, 2'd3, 2'd3));    // idle tick
    send_word(make_word(MODE_NONE, 2'd3, 2'd3));
    send_word(make_word(MODE_START, ChanNone, ActOpen));
    send_word(make_word(MODE_START, 2'd1, 2'd0));
    send_word(make_word(MODE_START, 2'd1, 2'd3));
    send_word(make_word(MODE_START, 2'd1, ActOpen));
    send_word(make_word(MODE_START, 2'd2, ActClose)); // busy
    send_word(make_word(MODE_TICK, 2'd0, 2'd0));
    send_word(make_word(MODE_TICK, 2'd0, 2'd0));
    send_word(make_word(MODE_TAKE, 2'd0, 2'd0));
    send_word(make_word(MODE_TAKE, 2'd0, 2'd0));
    send_word(make_word(MODE_START, 2'd3, ActClose));
    send_word(make_word(MODE_TICK, 2'd0, 2'd0));
    send_word(make_word(MODE_TICK, 2'd0, 2'd0));
    // a new start drops the untaken done event
    send_word(make_word(MODE_START, 2'd2, ActOpen));
    send_word(make_word(MODE_TICK, 2'd0, 2'd0));
    send_word(make_word(MODE_TICK, 2'd0, 2'd0));
    send_word(make_word(MODE_TAKE, 2'd0, 2'd0));
    drain_results();
    // widest thresholds, then shorten them while the sequence runs
    set_timing(16'hFFFF, 16'hFFFF);
    send_word(make_word(MODE_START, 2'd2, ActClose));
    send_word(make_word(MODE_TICK, 2'd0, 2'd0));
    send_word(make_word(MODE_TICK, 2'd0, 2'd0));
    drain_results();
    reg_access(REG_PULSE_TICKS, 1'b1, 16'd1);
    send_word(make_word(MODE_TICK, 2'd0, 2'd0));
    drain_results();
    reg_access(REG_FEEDBACK_TICKS, 1'b1, 16'd2);
    send_word(make_word(MODE_TICK, 2'd0, 2'd0));
    send_word(make_word(MODE_TICK, 2'd0, 2'd0));
    send_word(make_word(MODE_TAKE, 2'd0, 2'd0));
    drain_results();
  endtask

  task automatic test_backpressure();
    set_timing(16'd3, 16'd3);
    calm        = 1'b1;
    rx_hold_req = 200;
    repeat (40) send_word(rand_word());
    drain_results();
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    in_item_t    w;
    int unsigned counted;
    for (int ph = 0; ph < TrafficPhases; ph++) begin
      case (ph)
        0: set_timing(16'd0, 16'd0);
        1: set_timing(TickW'($urandom_range(20, 60)), TickW'($urandom_range(20, 60)));
        default: set_timing(TickW'($urandom_range(0, 6)), TickW'($urandom_range(0, 6)));
      endcase
      calm    = (ph == 3);
      counted = 0;
      while (counted < RandomWords / TrafficPhases) begin
        w = rand_word();
        counted++;
        send_word(w);
      end
      drain_results();
    end
    calm = 1'b0;
  endtask

  initial begin
    in_valid     = 1'b0;
    in_item      = '0;
    out_stall    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    rst_n        = 1'b0;
    calm         = 1'b0;
    rx_hold_req  = 0;
    rx_hold_left = 0;
    mismatches   = 0;
    cycle_count  = 0;
    relay_phase  = PH_IDLE;
    tick_count   = '0;
    run_chan     = ChanNone;
    run_act      = '0;
    done_held    = 1'b0;
    held_chan    = '0;
    held_act     = '0;
    pulse_limit  = PulseTicksRst;
    settle_limit = FeedbackTicksRst;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_reset();
    test_directed_sequence();
    test_backpressure();
    test_random_traffic();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/lrps_pkg.sv
hw/rtl/lrps_apb_regs.sv
hw/rtl/lrps_out_buf.sv
hw/rtl/latching_relay_pulse_sequencer_core.sv
bench/testbench.sv
